// ===== sv/fcs_pkg.sv =====
// Shared types, codes and helpers for the FABRIK chain solver.
package fcs_pkg;

	localparam int MAX_JOINTS_DEF = 32;
	localparam int COORD_BITS     = 32;
	localparam int IDX_W          = 5;
	localparam int LEN_W          = 31;
	localparam int TOL_W          = 17;
	localparam int ITER_W         = 8;
	localparam int ADDR_W         = 3;

	localparam logic [1:0] ACT_LOAD_POS = 2'd0;
	localparam logic [1:0] ACT_LOAD_LEN = 2'd1;
	localparam logic [1:0] ACT_SOLVE    = 2'd2;

	localparam logic REG_ITER_LIMIT = 1'b0;
	localparam logic REG_TOLERANCE  = 1'b1;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef struct packed {
		logic [1:0]        action;
		logic [IDX_W-1:0]  joint_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [LEN_W-1:0]  rest_length;
		logic [IDX_W-1:0]  root_index;
		logic [IDX_W-1:0]  effector_index;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
	} fcs_request_t;

	typedef struct packed {
		logic              status;
		logic [IDX_W-1:0]  out_index;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic              last;
		logic [ITER_W-1:0] iterations_used;
		logic              converged;
		logic [31:0]       reach_error;
	} fcs_result_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ROOT, S_EFF0, S_SQ, S_SQRT, S_EVAL, S_PASS, S_LD,
		S_DIVINIT, S_DIV, S_MUL, S_WR, S_RESTORE, S_OUTRD, S_OUT
	} fcs_state_t;

	typedef enum logic [1:0] {
		PH_FWD, PH_BWD, PH_ERR
	} fcs_phase_t;

	function automatic logic signed [31:0] sat_coord(input logic signed [33:0] v);
		logic signed [33:0] hi;
		logic signed [33:0] lo;
		hi = (34'sd1 <<< (COORD_BITS - 1)) - 34'sd1;
		lo = -hi - 34'sd1;
		if (v > hi)
			return hi[31:0];
		else if (v < lo)
			return lo[31:0];
		else
			return v[31:0];
	endfunction

endpackage

// ===== sv/fcs_ram.sv =====
// Generic simple dual-port RAM with registered read.
module fcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/fabrik_chain_solver.sv =====
// FABRIK chain solver top level: stores, APB registers and solve sequencer.
// Loads write the stores without leaving idle; a rejected solve strobes its status result
// the cycle after acceptance. A valid solve runs on one shared arithmetic unit; a segment
// visit: 3 squares, 32 root steps, divide/scale per component, load, write; degenerate ones
// skip divide/scale. Results stream one per cycle, effector first; no stall possible.
// Asynchronous reset clears loaded flags and control; registers return to limit 20, tolerance 1.
module fabrik_chain_solver #(
	parameter int MAX_JOINTS = fcs_pkg::MAX_JOINTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  fcs_pkg::fcs_request_t       request,
	output logic                        strobe,
	output fcs_pkg::fcs_result_t        result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fcs_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int AW = $clog2(MAX_JOINTS);

	fcs_pkg::fcs_state_t state_q, state_d;
	fcs_pkg::fcs_phase_t phase_q;

	logic [fcs_pkg::ITER_W-1:0] iter_limit_q;
	logic [fcs_pkg::TOL_W-1:0]  tolerance_q;
	logic [fcs_pkg::TOL_W-1:0]  tol_eff;
	logic [MAX_JOINTS-1:0]      pos_loaded_q;
	logic [MAX_JOINTS-1:0]      len_loaded_q;

	logic              j_we;
	logic [AW-1:0]     j_waddr, j_raddr;
	logic [95:0]       j_wdata, j_rdata;
	logic              l_we;
	logic [AW-1:0]     l_waddr, l_raddr;
	logic [30:0]       l_rdata;

	logic signed [31:0] t_q [3];
	logic signed [31:0] root_q [3];
	logic signed [31:0] b_q [3];
	logic signed [31:0] new_q [3];
	logic signed [31:0] rd_c [3];
	logic signed [32:0] d_q [3];
	logic [30:0]        dist_q;
	logic [1:0]         s_q;
	logic [30:0]        sm_q [3];
	logic [63:0]        v_q, rt_q, bb_q;
	logic [33:0]        err_q;
	logic [1:0]         comp_q;
	logic [4:0]         dcnt_q;
	logic [31:0]        rem_q;
	logic [16:0]        quo_q;
	logic [AW-1:0]      a_q, r_q, e_q;
	logic [fcs_pkg::ITER_W-1:0] it_q;
	logic               conv_q;
	logic               first_q;

	logic               accept;
	logic               chain_ok;
	logic               load_ok;
	logic [32:0]        m_c [3];
	logic [32:0]        mx_c;
	logic [1:0]         s_c;
	logic [30:0]        sm_c [3];
	logic [61:0]        sq_c;
	logic [63:0]        rb_c;
	logic [33:0]        len_c;
	logic               le_c;
	logic               bit_c;
	logic [32:0]        r2_c;
	logic               ge_c;
	logic [47:0]        prod_c;
	logic signed [33:0] off_c;

	assign accept  = start && !busy;
	assign pready  = 1'b1;
	assign tol_eff = (tolerance_q == '0) ? fcs_pkg::TOL_W'(1) : tolerance_q;
	assign load_ok = 32'(request.joint_index) < MAX_JOINTS;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_limit_q <= fcs_pkg::ITER_W'(20);
			tolerance_q  <= fcs_pkg::TOL_W'(1);
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				fcs_pkg::REG_ITER_LIMIT: iter_limit_q <= pwdata[fcs_pkg::ITER_W-1:0];
				default:                 tolerance_q  <= pwdata[fcs_pkg::TOL_W-1:0];
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			fcs_pkg::REG_ITER_LIMIT: prdata = 32'(iter_limit_q);
			default:                 prdata = 32'(tolerance_q);
		endcase
	end

	// chain check for a solve request
	always_comb begin
		chain_ok = 32'(request.root_index) < MAX_JOINTS
			&& 32'(request.effector_index) < MAX_JOINTS
			&& request.effector_index > request.root_index;
		for (int i = 0; i < MAX_JOINTS; i++) begin
			if (i >= 32'(request.root_index) && i <= 32'(request.effector_index)
					&& !pos_loaded_q[i])
				chain_ok = 1'b0;
			if (i < 32'(request.effector_index) - 32'(request.root_index)
					&& !len_loaded_q[i])
				chain_ok = 1'b0;
		end
	end

	fcs_ram #(.WIDTH(96), .DEPTH(MAX_JOINTS)) u_joint_ram (
		.clk(clk), .we(j_we), .waddr(j_waddr), .wdata(j_wdata),
		.raddr(j_raddr), .rdata(j_rdata)
	);

	fcs_ram #(.WIDTH(fcs_pkg::LEN_W), .DEPTH(MAX_JOINTS)) u_len_ram (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(request.rest_length),
		.raddr(l_raddr), .rdata(l_rdata)
	);

	assign rd_c[0] = j_rdata[95:64];
	assign rd_c[1] = j_rdata[63:32];
	assign rd_c[2] = j_rdata[31:0];

	// shared arithmetic
	always_comb begin
		mx_c = '0;
		for (int k = 0; k < 3; k++) begin
			m_c[k] = d_q[k][32] ? 33'(-d_q[k]) : 33'(d_q[k]);
			if (m_c[k] > mx_c)
				mx_c = m_c[k];
		end
		s_c = mx_c[32] ? 2'd2 : (mx_c[31] ? 2'd1 : 2'd0);
		for (int k = 0; k < 3; k++)
			sm_c[k] = 31'(m_c[k] >> s_c);
		sq_c   = sm_c[comp_q] * sm_c[comp_q];
		rb_c   = rt_q + bb_q;
		len_c  = 34'(rt_q[31:0]) << s_q;
		le_c   = len_c <= 34'(tol_eff);
		bit_c  = (dcnt_q == 5'd16) ? sm_q[comp_q][0] : 1'b0;
		r2_c   = {rem_q, bit_c};
		ge_c   = r2_c >= {1'b0, rt_q[31:0]};
		prod_c = quo_q * dist_q;
		off_c  = d_q[comp_q][32] ? -34'(prod_c[47:16]) : 34'(prod_c[47:16]);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fcs_pkg::S_IDLE:
				if (accept && request.action == fcs_pkg::ACT_SOLVE && chain_ok)
					state_d = fcs_pkg::S_ROOT;
			fcs_pkg::S_ROOT:    state_d = fcs_pkg::S_EFF0;
			fcs_pkg::S_EFF0:    state_d = fcs_pkg::S_SQ;
			fcs_pkg::S_SQ:
				if (comp_q == 2'd2)
					state_d = fcs_pkg::S_SQRT;
			fcs_pkg::S_SQRT:
				if (bb_q[0])
					state_d = fcs_pkg::S_EVAL;
			fcs_pkg::S_EVAL:
				if (phase_q == fcs_pkg::PH_ERR) begin
					if (first_q)
						state_d = (iter_limit_q == '0) ? fcs_pkg::S_OUTRD : fcs_pkg::S_PASS;
					else if (le_c || it_q == iter_limit_q)
						state_d = fcs_pkg::S_OUTRD;
					else
						state_d = fcs_pkg::S_PASS;
				end else if (len_c < 34'(tol_eff)) begin
					state_d = fcs_pkg::S_WR;
				end else begin
					state_d = fcs_pkg::S_DIVINIT;
				end
			fcs_pkg::S_PASS:    state_d = fcs_pkg::S_LD;
			fcs_pkg::S_LD:      state_d = fcs_pkg::S_SQ;
			fcs_pkg::S_DIVINIT: state_d = fcs_pkg::S_DIV;
			fcs_pkg::S_DIV:
				if (dcnt_q == '0)
					state_d = fcs_pkg::S_MUL;
			fcs_pkg::S_MUL:
				state_d = (comp_q == 2'd2) ? fcs_pkg::S_WR : fcs_pkg::S_DIVINIT;
			fcs_pkg::S_WR:
				if (phase_q == fcs_pkg::PH_FWD)
					state_d = (a_q == r_q) ? fcs_pkg::S_RESTORE : fcs_pkg::S_LD;
				else
					state_d = (a_q == e_q) ? fcs_pkg::S_SQ : fcs_pkg::S_LD;
			fcs_pkg::S_RESTORE: state_d = fcs_pkg::S_LD;
			fcs_pkg::S_OUTRD:   state_d = fcs_pkg::S_OUT;
			fcs_pkg::S_OUT:
				if (a_q == r_q)
					state_d = fcs_pkg::S_IDLE;
			default:            state_d = fcs_pkg::S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		busy    = state_q != fcs_pkg::S_IDLE;
		j_we    = 1'b0;
		j_waddr = a_q;
		j_wdata = {new_q[0], new_q[1], new_q[2]};
		j_raddr = a_q;
		l_we    = 1'b0;
		l_waddr = AW'(request.joint_index);
		l_raddr = '0;
		unique case (state_q)
			fcs_pkg::S_IDLE: begin
				j_waddr = AW'(request.joint_index);
				j_wdata = {request.pos_x, request.pos_y, request.pos_z};
				j_we    = accept && request.action == fcs_pkg::ACT_LOAD_POS && load_ok;
				l_we    = accept && request.action == fcs_pkg::ACT_LOAD_LEN && load_ok;
				j_raddr = AW'(request.root_index);
			end
			fcs_pkg::S_ROOT:  j_raddr = e_q;
			fcs_pkg::S_PASS: begin
				j_we    = 1'b1;
				j_waddr = e_q;
				j_wdata = {t_q[0], t_q[1], t_q[2]};
				j_raddr = e_q - AW'(1);
				l_raddr = e_q - AW'(1) - r_q;
			end
			fcs_pkg::S_WR: begin
				j_we = 1'b1;
				if (phase_q == fcs_pkg::PH_FWD) begin
					j_raddr = a_q - AW'(1);
					l_raddr = a_q - AW'(1) - r_q;
				end else begin
					j_raddr = a_q + AW'(1);
					l_raddr = a_q - r_q;
				end
			end
			fcs_pkg::S_RESTORE: begin
				j_we    = 1'b1;
				j_waddr = r_q;
				j_wdata = {root_q[0], root_q[1], root_q[2]};
				j_raddr = r_q + AW'(1);
			end
			fcs_pkg::S_OUTRD: j_raddr = e_q;
			fcs_pkg::S_OUT:   j_raddr = a_q - AW'(1);
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fcs_pkg::S_IDLE;
			pos_loaded_q <= '0;
			len_loaded_q <= '0;
			strobe       <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= (state_q == fcs_pkg::S_OUT)
				|| (state_q == fcs_pkg::S_IDLE && accept
					&& request.action == fcs_pkg::ACT_SOLVE && !chain_ok);
			if (accept && load_ok && request.action == fcs_pkg::ACT_LOAD_POS)
				pos_loaded_q[AW'(request.joint_index)] <= 1'b1;
			if (accept && load_ok && request.action == fcs_pkg::ACT_LOAD_LEN)
				len_loaded_q[AW'(request.joint_index)] <= 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			fcs_pkg::S_IDLE: begin
				r_q     <= AW'(request.root_index);
				e_q     <= AW'(request.effector_index);
				t_q[0]  <= fcs_pkg::sat_coord(34'(request.target_x));
				t_q[1]  <= fcs_pkg::sat_coord(34'(request.target_y));
				t_q[2]  <= fcs_pkg::sat_coord(34'(request.target_z));
				it_q    <= '0;
				conv_q  <= 1'b0;
				first_q <= 1'b1;
				result  <= '{status: fcs_pkg::STATUS_REJECT, out_index: '0, out_x: '0,
					out_y: '0, out_z: '0, last: 1'b1, iterations_used: '0,
					converged: 1'b0, reach_error: '0};
			end
			fcs_pkg::S_ROOT:
				for (int k = 0; k < 3; k++)
					root_q[k] <= rd_c[k];
			fcs_pkg::S_EFF0: begin
				for (int k = 0; k < 3; k++)
					d_q[k] <= 33'(rd_c[k]) - 33'(t_q[k]);
				phase_q <= fcs_pkg::PH_ERR;
				comp_q  <= '0;
			end
			fcs_pkg::S_SQ: begin
				s_q <= s_c;
				for (int k = 0; k < 3; k++)
					sm_q[k] <= sm_c[k];
				v_q    <= (comp_q == '0) ? 64'(sq_c) : v_q + 64'(sq_c);
				rt_q   <= '0;
				bb_q   <= 64'(1) << 62;
				comp_q <= comp_q + 2'd1;
			end
			fcs_pkg::S_SQRT: begin
				if (v_q >= rb_c) begin
					v_q  <= v_q - rb_c;
					rt_q <= (rt_q >> 1) + bb_q;
				end else begin
					rt_q <= rt_q >> 1;
				end
				bb_q <= bb_q >> 2;
			end
			fcs_pkg::S_EVAL: begin
				comp_q <= '0;
				if (phase_q == fcs_pkg::PH_ERR) begin
					err_q   <= len_c;
					first_q <= 1'b0;
					if (first_q)
						conv_q <= iter_limit_q == '0 && le_c;
					else
						conv_q <= le_c;
				end else begin
					new_q[0] <= b_q[0];
					new_q[1] <= fcs_pkg::sat_coord(34'(b_q[1]) + 34'(dist_q));
					new_q[2] <= b_q[2];
				end
			end
			fcs_pkg::S_PASS: begin
				it_q    <= it_q + fcs_pkg::ITER_W'(1);
				phase_q <= fcs_pkg::PH_FWD;
				a_q     <= e_q - AW'(1);
				for (int k = 0; k < 3; k++)
					b_q[k] <= t_q[k];
			end
			fcs_pkg::S_LD: begin
				for (int k = 0; k < 3; k++)
					d_q[k] <= 33'(rd_c[k]) - 33'(b_q[k]);
				dist_q <= l_rdata;
				comp_q <= '0;
			end
			fcs_pkg::S_DIVINIT: begin
				rem_q  <= 32'(sm_q[comp_q][30:1]);
				quo_q  <= '0;
				dcnt_q <= 5'd16;
			end
			fcs_pkg::S_DIV: begin
				rem_q  <= ge_c ? 32'(r2_c - {1'b0, rt_q[31:0]}) : r2_c[31:0];
				quo_q  <= {quo_q[15:0], ge_c};
				dcnt_q <= dcnt_q - 5'd1;
			end
			fcs_pkg::S_MUL: begin
				new_q[comp_q] <= fcs_pkg::sat_coord(34'(b_q[comp_q]) + off_c);
				comp_q        <= comp_q + 2'd1;
			end
			fcs_pkg::S_WR: begin
				comp_q <= '0;
				for (int k = 0; k < 3; k++)
					b_q[k] <= new_q[k];
				if (phase_q == fcs_pkg::PH_FWD) begin
					a_q <= a_q - AW'(1);
				end else if (a_q == e_q) begin
					phase_q <= fcs_pkg::PH_ERR;
					for (int k = 0; k < 3; k++)
						d_q[k] <= 33'(new_q[k]) - 33'(t_q[k]);
				end else begin
					a_q <= a_q + AW'(1);
				end
			end
			fcs_pkg::S_RESTORE: begin
				phase_q <= fcs_pkg::PH_BWD;
				a_q     <= r_q + AW'(1);
				for (int k = 0; k < 3; k++)
					b_q[k] <= root_q[k];
			end
			fcs_pkg::S_OUTRD: a_q <= e_q;
			fcs_pkg::S_OUT: begin
				result <= '{status: fcs_pkg::STATUS_OK, out_index: fcs_pkg::IDX_W'(a_q),
					out_x: rd_c[0], out_y: rd_c[1], out_z: rd_c[2], last: a_q == r_q,
					iterations_used: it_q, converged: conv_q,
					reach_error: (err_q > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : err_q[31:0]};
				a_q    <= a_q - AW'(1);
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/fcs_checker.sv =====
// Port-level assertions for the FABRIK chain solver, bound to the top level.
module fcs_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input fcs_pkg::fcs_request_t request,
	input logic                  strobe,
	input fcs_pkg::fcs_result_t  result
);

	// results of one solve come back to back
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("result stream broken before last");

	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status == fcs_pkg::STATUS_REJECT |-> result.last)
		else $error("reject status without last");

	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("idle while results pending");

	a_solve_resp: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.action == fcs_pkg::ACT_SOLVE |=> busy || strobe)
		else $error("solve request dropped");

endmodule

bind fabrik_chain_solver fcs_checker u_fcs_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.request(request), .strobe(strobe), .result(result)
);

// ===== tb/sv/tb_fabrik_chain_solver.sv =====
// Self-checking testbench for the FABRIK chain solver: directed and random requests, APB setup.
module tb_fabrik_chain_solver;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	fcs_pkg::fcs_request_t request;
	logic strobe;
	fcs_pkg::fcs_result_t result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [fcs_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	fabrik_chain_solver u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.strobe(strobe), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	fcs_pkg::fcs_request_t pending_reqs[$];
	fcs_pkg::fcs_result_t expected_joints[$];
	int errors = 0;
	int accepted = 0;

	// solver model state
	longint jx[32];
	longint jy[32];
	longint jz[32];
	longint unsigned seg_len[32];
	bit [31:0] pos_loaded;
	bit [31:0] len_loaded;
	int unsigned iter_limit;
	int unsigned tol_reg;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned vec_len(input longint d[3],
			output longint unsigned sm[3], output longint unsigned slen);
		longint unsigned m[3];
		longint unsigned mx;
		longint unsigned sum;
		int s;
		mx = 0;
		sum = 0;
		s = 0;
		for (int k = 0; k < 3; k++) begin
			m[k] = d[k] < 0 ? -d[k] : d[k];
			if (m[k] > mx)
				mx = m[k];
		end
		while ((mx >> s) >= (64'd1 << 31))
			s++;
		for (int k = 0; k < 3; k++) begin
			sm[k] = m[k] >> s;
			sum += sm[k] * sm[k];
		end
		slen = isqrt(sum);
		return slen << s;
	endfunction

	function automatic void move_joint(int a, int b, longint unsigned seg_dist,
			longint unsigned tol);
		longint d[3];
		longint off[3];
		longint unsigned sm[3];
		longint unsigned slen;
		longint unsigned len;
		longint unsigned um;
		longint om;
		d[0] = jx[a] - jx[b];
		d[1] = jy[a] - jy[b];
		d[2] = jz[a] - jz[b];
		len = vec_len(d, sm, slen);
		if (len < tol) begin
			off[0] = 0;
			off[1] = longint'(seg_dist);
			off[2] = 0;
		end else begin
			for (int k = 0; k < 3; k++) begin
				um = (sm[k] << 16) / slen;
				om = longint'((um * seg_dist) >> 16);
				off[k] = d[k] < 0 ? -om : om;
			end
		end
		jx[a] = sat32(jx[b] + off[0]);
		jy[a] = sat32(jy[b] + off[1]);
		jz[a] = sat32(jz[b] + off[2]);
	endfunction

	function automatic longint unsigned effector_error(int e, longint t[3]);
		longint d[3];
		longint unsigned sm[3];
		longint unsigned slen;
		d[0] = jx[e] - t[0];
		d[1] = jy[e] - t[1];
		d[2] = jz[e] - t[2];
		return vec_len(d, sm, slen);
	endfunction

	// applies an accepted request and queues the joints it should emit
	function automatic void solve_chain(fcs_pkg::fcs_request_t q);
		int r;
		int e;
		bit ok;
		longint unsigned tol;
		longint unsigned err;
		int unsigned iters;
		bit conv;
		longint t[3];
		longint rx;
		longint ry;
		longint rz;
		fcs_pkg::fcs_result_t o;
		r = int'(q.root_index);
		e = int'(q.effector_index);
		tol = tol_reg == 0 ? 1 : tol_reg;
		if (q.action == fcs_pkg::ACT_LOAD_POS) begin
			jx[q.joint_index] = q.pos_x;
			jy[q.joint_index] = q.pos_y;
			jz[q.joint_index] = q.pos_z;
			pos_loaded[q.joint_index] = 1'b1;
			return;
		end
		if (q.action == fcs_pkg::ACT_LOAD_LEN) begin
			seg_len[q.joint_index] = 64'(q.rest_length);
			len_loaded[q.joint_index] = 1'b1;
			return;
		end
		if (q.action != fcs_pkg::ACT_SOLVE)
			return;
		ok = e > r;
		if (ok) begin
			for (int i = r; i <= e; i++)
				if (!pos_loaded[i])
					ok = 0;
			for (int i = 0; i < e - r; i++)
				if (!len_loaded[i])
					ok = 0;
		end
		o = '0;
		if (!ok) begin
			o.status = fcs_pkg::STATUS_REJECT;
			o.last = 1'b1;
			expected_joints.insert(expected_joints.size(), o);
			return;
		end
		t[0] = q.target_x;
		t[1] = q.target_y;
		t[2] = q.target_z;
		rx = jx[r];
		ry = jy[r];
		rz = jz[r];
		iters = iter_limit;
		conv = 0;
		err = effector_error(e, t);
		if (iter_limit == 0 && err <= tol)
			conv = 1;
		for (int it = 0; it < iter_limit; it++) begin
			jx[e] = t[0];
			jy[e] = t[1];
			jz[e] = t[2];
			for (int i = e; i > r; i--)
				move_joint(i - 1, i, seg_len[i - 1 - r], tol);
			jx[r] = rx;
			jy[r] = ry;
			jz[r] = rz;
			for (int i = r; i < e; i++)
				move_joint(i + 1, i, seg_len[i - r], tol);
			err = effector_error(e, t);
			if (err <= tol) begin
				conv = 1;
				iters = it + 1;
				break;
			end
		end
		if (err > 64'hFFFFFFFF)
			err = 64'hFFFFFFFF;
		for (int j = e; j >= r; j--) begin
			o.status = fcs_pkg::STATUS_OK;
			o.out_index = 5'(j);
			o.out_x = jx[j][31:0];
			o.out_y = jy[j][31:0];
			o.out_z = jz[j][31:0];
			o.last = j == r;
			o.iterations_used = 8'(iters);
			o.converged = conv;
			o.reach_error = err[31:0];
			expected_joints.insert(expected_joints.size(), o);
		end
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				solve_chain(pending_reqs.pop_front());
				accepted++;
			end
			if (pending_reqs.size() != 0 &&
					((accepted > 110 && accepted < 170) || $urandom_range(99) >= 6)) begin
				start <= 1'b1;
				request <= pending_reqs[0];
			end else
				start <= 1'b0;
		end
	end

	function automatic void check_field(string name, longint unsigned exp_v,
			longint unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// result monitor
	always @(posedge clk) begin
		fcs_pkg::fcs_result_t x;
		if (arst_n && strobe) begin
			if (expected_joints.size() == 0) begin
				$display("%0t unexpected result %p", $time, result);
				errors++;
			end else begin
				x = expected_joints.pop_front();
				check_field("status", x.status, result.status);
				check_field("out_index", x.out_index, result.out_index);
				check_field("out_x", x.out_x, result.out_x);
				check_field("out_y", x.out_y, result.out_y);
				check_field("out_z", x.out_z, result.out_z);
				check_field("last", x.last, result.last);
				check_field("iterations_used", x.iterations_used, result.iterations_used);
				check_field("converged", x.converged, result.converged);
				check_field("reach_error", x.reach_error, result.reach_error);
			end
		end
	end

	function automatic void push_pos(int j, int x, int y, int z);
		fcs_pkg::fcs_request_t q;
		q = '0;
		q.action = fcs_pkg::ACT_LOAD_POS;
		q.joint_index = 5'(j);
		q.pos_x = x;
		q.pos_y = y;
		q.pos_z = z;
		pending_reqs.insert(pending_reqs.size(), q);
	endfunction

	function automatic void push_len(int j, bit [30:0] l);
		fcs_pkg::fcs_request_t q;
		q = '0;
		q.action = fcs_pkg::ACT_LOAD_LEN;
		q.joint_index = 5'(j);
		q.rest_length = l;
		pending_reqs.insert(pending_reqs.size(), q);
	endfunction

	function automatic void push_solve(int r, int e, int tx, int ty, int tz);
		fcs_pkg::fcs_request_t q;
		q = '0;
		q.action = fcs_pkg::ACT_SOLVE;
		q.root_index = 5'(r);
		q.effector_index = 5'(e);
		q.target_x = tx;
		q.target_y = ty;
		q.target_z = tz;
		pending_reqs.insert(pending_reqs.size(), q);
	endfunction

	function automatic int rnd_coord();
		if ($urandom_range(99) < 85)
			return int'($urandom_range(1 << 22)) - (1 << 21);
		return int'($urandom);
	endfunction

	function automatic bit [30:0] rnd_len();
		int p;
		p = int'($urandom_range(99));
		if (p < 5)
			return '0;
		if (p < 85)
			return 31'($urandom_range(1 << 20));
		return 31'($urandom);
	endfunction

	// mostly well-formed chains: positions, lengths, then solves; some noise
	task automatic fill_random(int count, int max_seg);
		int n;
		int r;
		int p;
		bit [255:0] noise;
		fcs_pkg::fcs_request_t q;
		while (count > 0) begin
			p = int'($urandom_range(99));
			if (p < 10) begin
				noise = {$urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom};
				q = fcs_pkg::fcs_request_t'(noise[$bits(fcs_pkg::fcs_request_t)-1:0]);
				if (p < 4)
					q.action = 2'd3;
				else if (p < 7) begin
					q.action = fcs_pkg::ACT_SOLVE;
					q.effector_index = 5'($urandom_range(q.root_index));
				end
				pending_reqs.insert(pending_reqs.size(), q);
				count--;
			end else begin
				n = $urandom_range(99) < 8 ? int'($urandom_range(4, max_seg)) :
					int'($urandom_range(1, max_seg < 3 ? max_seg : 3));
				r = int'($urandom_range(31 - n));
				for (int j = r; j <= r + n; j++)
					push_pos(j, rnd_coord(), rnd_coord(), rnd_coord());
				for (int k = 0; k < n; k++)
					push_len(k, rnd_len());
				push_solve(r, r + n, rnd_coord(), rnd_coord(), rnd_coord());
				if ($urandom_range(3) == 0)
					push_solve(r, r + n, rnd_coord(), rnd_coord(), rnd_coord());
				count -= 2 * n + 2;
			end
		end
	endtask

	task automatic drain();
		wait (pending_reqs.size() == 0 && !start);
		wait (expected_joints.size() == 0 && !busy);
		repeat (20) @(posedge clk);
	endtask

	task automatic apb_write(logic [fcs_pkg::ADDR_W-1:0] addr, logic [31:0] data);
		logic [31:0] readback;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == fcs_pkg::ADDR_W'(4 * fcs_pkg::REG_ITER_LIMIT)) begin
			iter_limit = data[7:0];
			readback = 32'(data[7:0]);
		end else begin
			tol_reg = data[16:0];
			readback = 32'(data[16:0]);
		end
		@(posedge clk);
		check_field("prdata", readback, prdata);
	endtask

	task automatic run_phase(int lim, int tol, int count, int max_seg);
		drain();
		apb_write(fcs_pkg::ADDR_W'(4 * fcs_pkg::REG_ITER_LIMIT), lim);
		apb_write(fcs_pkg::ADDR_W'(4 * fcs_pkg::REG_TOLERANCE), tol);
		fill_random(count, max_seg);
	endtask

	initial begin
		start = 1'b0;
		request = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pos_loaded = '0;
		len_loaded = '0;
		iter_limit = 20;
		tol_reg = 1;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, rejects, degenerate segment, unknown action
		push_solve(0, 1, 0, 0, 0);
		push_pos(0, 32'h7FFFFFFF, 32'h80000000, 0);
		push_pos(1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
		push_pos(2, 0, 0, 0);
		push_pos(3, 0, 0, 0);
		push_len(0, 31'h7FFFFFFF);
		push_len(1, 0);
		push_len(2, 31'h10000);
		push_solve(0, 1, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
		push_solve(2, 3, 0, 32'h8000, 0);
		push_solve(2, 2, 0, 0, 0);
		push_solve(3, 2, 0, 0, 0);
		push_solve(2, 5, 0, 0, 0);
		push_pos(4, 32'h30000, 0, 0);
		push_solve(1, 4, 0, 0, 0);
		push_solve(0, 3, 32'h20000, 32'h10000, 0);
		pending_reqs.insert(pending_reqs.size(), fcs_pkg::fcs_request_t'(
			{2'd3, {($bits(fcs_pkg::fcs_request_t) - 2){1'b1}}}));
		push_pos(31, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		push_solve(30, 31, 0, 0, 0);

		run_phase(20, 1, 60, 5);
		run_phase(1, 65536, 50, 3);
		run_phase(255, 1, 12, 1);
		run_phase(0, 0, 20, 3);
		run_phase(2, 300, 20, 3);
		for (int j = 0; j < 32; j++)
			push_pos(j, rnd_coord(), rnd_coord(), rnd_coord());
		for (int k = 0; k < 31; k++)
			push_len(k, rnd_len());
		push_solve(0, 31, rnd_coord(), rnd_coord(), rnd_coord());
		run_phase(6, 4096, 50, 5);

		drain();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#80000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
